[hdl/ubxfe_pkg.sv]
// Shared types and constants for the UBX frame encoder.
`default_nettype none
package ubxfe_pkg;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

    localparam int OUT_DEPTH = 2;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [15:0] LIMIT_RESET = 16'd512;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       rejected;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] len;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } t_phase;

endpackage
`default_nettype wire

[hdl/ubx_frame_encoder.sv]
// Top level of the UBX frame encoder.
// Takes one input word per cycle while full is low. A start word expands into up to nine
// output words (six header bytes, the first payload byte, CK_A and CK_B) and a payload
// word into one to three; the byte sequencer emits one output word per cycle while a
// command is queued and the output buffer has room, so the output side sets the rate. A
// four-entry command queue lets input words run ahead while a header is still being sent,
// and a two-entry output buffer holds finished words until popped. The limit register is
// written through the cfg channel, which is always ready; it resets to 512.
`default_nettype none
module ubx_frame_encoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [15:0]           i_cfg_data,
    input  wire                   push,
    output logic                  full,
    input  ubxfe_pkg::t_in_word   i_in_word,
    output logic                  empty,
    input  wire                   pop,
    output ubxfe_pkg::t_out_word  o_out_word
);

    logic             cmd_push;
    ubxfe_pkg::t_cmd  cmd_in;
    logic             cmd_empty;
    ubxfe_pkg::t_cmd  cmd_head;
    logic             cmd_pop;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    ubxfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in_word   (i_in_word),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    ubxfe_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_head)
    );

    ubxfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

[hdl/ubxfe_front.sv]
// Front end: length check, frame tracking and command generation.
`default_nettype none
module ubxfe_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire  [15:0]          i_cfg_data,
    input  wire                  i_accept,
    input  ubxfe_pkg::t_in_word  i_in_word,
    output logic                 o_cmd_push,
    output ubxfe_pkg::t_cmd      o_cmd
);

    logic [15:0] r_limit;
    logic        r_in_frame;
    logic [15:0] r_bytes_left;
    logic        n_in_frame;
    logic [15:0] n_bytes_left;

    always_comb begin
        n_in_frame         = r_in_frame;
        n_bytes_left       = r_bytes_left;
        o_cmd_push         = 1'b0;
        o_cmd.op           = ubxfe_pkg::OP_DATA;
        o_cmd.msg_class    = i_in_word.msg_class;
        o_cmd.msg_id       = i_in_word.msg_id;
        o_cmd.len          = i_in_word.payload_length;
        o_cmd.data         = i_in_word.data;
        o_cmd.last         = 1'b0;
        if (i_accept) begin
            if (i_in_word.cmd == ubxfe_pkg::CMD_START) begin
                o_cmd_push = 1'b1;
                if (i_in_word.payload_length > r_limit) begin
                    o_cmd.op     = ubxfe_pkg::OP_REJECT;
                    n_in_frame   = 1'b0;
                    n_bytes_left = '0;
                end else begin
                    o_cmd.op     = ubxfe_pkg::OP_START;
                    o_cmd.last   = (i_in_word.payload_length == 16'd1);
                    n_bytes_left = (i_in_word.payload_length == 16'd0) ? 16'd0
                                 : i_in_word.payload_length - 16'd1;
                    n_in_frame   = (i_in_word.payload_length > 16'd1);
                end
            end else if (r_in_frame && (r_bytes_left != 16'd0)) begin
                o_cmd_push   = 1'b1;
                o_cmd.op     = ubxfe_pkg::OP_DATA;
                o_cmd.last   = (r_bytes_left == 16'd1);
                n_bytes_left = r_bytes_left - 16'd1;
                n_in_frame   = (r_bytes_left != 16'd1);
            end else begin
                n_in_frame = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= ubxfe_pkg::LIMIT_RESET;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule
`default_nettype wire

[hdl/ubxfe_cmd_fifo.sv]
// Command queue between the front end and the byte sequencer.
`default_nettype none
module ubxfe_cmd_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  ubxfe_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output ubxfe_pkg::t_cmd  o_cmd
);

    ubxfe_pkg::t_cmd                  r_mem [ubxfe_pkg::CMD_DEPTH];
    logic [ubxfe_pkg::CMD_AW-1:0]     r_wr;
    logic [ubxfe_pkg::CMD_AW-1:0]     r_rd;
    logic [ubxfe_pkg::CMD_CW-1:0]     r_cnt;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full  = (r_cnt == ubxfe_pkg::CMD_CW'(ubxfe_pkg::CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == ubxfe_pkg::CMD_AW'(ubxfe_pkg::CMD_DEPTH - 1)) ? '0
                      : r_wr + ubxfe_pkg::CMD_AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == ubxfe_pkg::CMD_AW'(ubxfe_pkg::CMD_DEPTH - 1)) ? '0
                      : r_rd + ubxfe_pkg::CMD_AW'(1);
            end
            r_cnt <= r_cnt + ubxfe_pkg::CMD_CW'(wr_en) - ubxfe_pkg::CMD_CW'(rd_en);
        end
    end

endmodule
`default_nettype wire

[hdl/ubxfe_back.sv]
// Byte sequencer with Fletcher checksum and output word buffer.
`default_nettype none
module ubxfe_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_empty,
    input  ubxfe_pkg::t_cmd       i_cmd,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  wire                   i_pop,
    output ubxfe_pkg::t_out_word  o_out_word
);

    ubxfe_pkg::t_phase               r_phase;
    logic                            r_mid;
    logic [7:0]                      r_sum_a;
    logic [7:0]                      r_sum_b;
    ubxfe_pkg::t_out_word            r_out_mem [ubxfe_pkg::OUT_DEPTH];
    logic [ubxfe_pkg::OUT_AW-1:0]    r_out_wr;
    logic [ubxfe_pkg::OUT_AW-1:0]    r_out_rd;
    logic [ubxfe_pkg::OUT_CW-1:0]    r_out_cnt;

    ubxfe_pkg::t_phase               phase;
    ubxfe_pkg::t_phase               n_phase;
    logic                            n_mid;
    logic [7:0]                      n_sum_a;
    logic [7:0]                      n_sum_b;
    logic                            fire;
    logic                            done;
    logic                            add;
    ubxfe_pkg::t_out_word            word;
    logic                            rd_en;

    assign fire      = !i_cmd_empty
                     && (r_out_cnt != ubxfe_pkg::OUT_CW'(ubxfe_pkg::OUT_DEPTH));
    assign o_cmd_pop = fire && done;
    assign o_empty   = (r_out_cnt == '0);
    assign o_out_word = r_out_mem[r_out_rd];
    assign rd_en     = i_pop && !o_empty;

    always_comb begin
        phase = r_mid ? r_phase
              : ((i_cmd.op == ubxfe_pkg::OP_DATA) ? ubxfe_pkg::PH_PAYLOAD
                                                  : ubxfe_pkg::PH_SYNC1);
        word           = '0;
        done           = 1'b0;
        add            = 1'b0;
        n_phase        = phase;
        if (i_cmd.op == ubxfe_pkg::OP_REJECT) begin
            word.rejected = 1'b1;
            done          = 1'b1;
        end else begin
            unique case (phase)
                ubxfe_pkg::PH_SYNC1: begin
                    word.out_byte = ubxfe_pkg::SYNC_FIRST;
                    n_phase       = ubxfe_pkg::PH_SYNC2;
                end
                ubxfe_pkg::PH_SYNC2: begin
                    word.out_byte = ubxfe_pkg::SYNC_SECOND;
                    n_phase       = ubxfe_pkg::PH_CLASS;
                end
                ubxfe_pkg::PH_CLASS: begin
                    word.out_byte = i_cmd.msg_class;
                    add           = 1'b1;
                    n_phase       = ubxfe_pkg::PH_ID;
                end
                ubxfe_pkg::PH_ID: begin
                    word.out_byte = i_cmd.msg_id;
                    add           = 1'b1;
                    n_phase       = ubxfe_pkg::PH_LEN_LO;
                end
                ubxfe_pkg::PH_LEN_LO: begin
                    word.out_byte = i_cmd.len[7:0];
                    add           = 1'b1;
                    n_phase       = ubxfe_pkg::PH_LEN_HI;
                end
                ubxfe_pkg::PH_LEN_HI: begin
                    word.out_byte = i_cmd.len[15:8];
                    add           = 1'b1;
                    n_phase       = (i_cmd.len == 16'd0) ? ubxfe_pkg::PH_CK_A
                                                         : ubxfe_pkg::PH_PAYLOAD;
                end
                ubxfe_pkg::PH_PAYLOAD: begin
                    word.out_byte = i_cmd.data;
                    add           = 1'b1;
                    n_phase       = ubxfe_pkg::PH_CK_A;
                    done          = !i_cmd.last;
                end
                ubxfe_pkg::PH_CK_A: begin
                    word.out_byte = r_sum_a;
                    n_phase       = ubxfe_pkg::PH_CK_B;
                end
                ubxfe_pkg::PH_CK_B: begin
                    word.out_byte  = r_sum_b;
                    word.frame_end = 1'b1;
                    done           = 1'b1;
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end
        word.run_last = done;

        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_mid   = r_mid;
        if (fire) begin
            n_mid = !done;
            if ((i_cmd.op == ubxfe_pkg::OP_START) && (phase == ubxfe_pkg::PH_SYNC1)) begin
                n_sum_a = '0;
                n_sum_b = '0;
            end else if (add) begin
                n_sum_a = r_sum_a + word.out_byte;
                n_sum_b = r_sum_b + n_sum_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mem[r_out_wr] <= word;
        end
        if (fire && !done) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_out_wr  <= '0;
            r_out_rd  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_mid   <= n_mid;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            if (fire) begin
                r_out_wr <= (r_out_wr == ubxfe_pkg::OUT_AW'(ubxfe_pkg::OUT_DEPTH - 1)) ? '0
                          : r_out_wr + 1'b1;
            end
            if (rd_en) begin
                r_out_rd <= (r_out_rd == ubxfe_pkg::OUT_AW'(ubxfe_pkg::OUT_DEPTH - 1)) ? '0
                          : r_out_rd + 1'b1;
            end
            r_out_cnt <= r_out_cnt + ubxfe_pkg::OUT_CW'(fire) - ubxfe_pkg::OUT_CW'(rd_en);
        end
    end

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the UBX frame encoder: a directed table, then random frames.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 40;
    localparam int PHASE_WORDS = 38;

    typedef enum logic [1:0] {
        ROW_CHECK,
        ROW_QUIET,
        ROW_REJECT,
        ROW_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        ubxfe_pkg::t_in_word  w;
    } t_row;

    localparam ubxfe_pkg::t_out_word REJECT_WORD = {8'h00, 1'b1, 1'b0, 1'b1};

    // kind, cmd, class, id, length (limit value on ROW_LIMIT), data
    localparam t_row PLAN [22] = '{
        {ROW_QUIET,  ubxfe_pkg::CMD_DATA,  8'hFF, 8'hFF, 16'hFFFF, 8'hFF},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h00, 8'h00, 16'd0,    8'h00},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'hFF, 8'hFF, 16'd1,    8'hFF},
        {ROW_REJECT, ubxfe_pkg::CMD_START, 8'h01, 8'h02, 16'd513,  8'h00},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h06, 8'h01, 16'd512,  8'hAA},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h55},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h00},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h0A, 8'h04, 16'd2,    8'h5A},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'hA5},
        {ROW_QUIET,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h33},
        {ROW_REJECT, ubxfe_pkg::CMD_START, 8'h80, 8'h7F, 16'hFFFF, 8'hFF},
        {ROW_LIMIT,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h00},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h05, 8'h01, 16'd0,    8'h00},
        {ROW_REJECT, ubxfe_pkg::CMD_START, 8'h05, 8'h00, 16'd1,    8'h12},
        {ROW_LIMIT,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'hFFFF, 8'h00},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h0B, 8'h30, 16'hFFFF, 8'hC3},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h3C},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'hFF},
        {ROW_CHECK,  ubxfe_pkg::CMD_START, 8'h01, 8'h07, 16'd3,    8'h11},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h22},
        {ROW_CHECK,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h33},
        {ROW_QUIET,  ubxfe_pkg::CMD_DATA,  8'h00, 8'h00, 16'd0,    8'h44}
    };

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [15:0]           i_cfg_data  = '0;
    logic                  push        = 1'b0;
    ubxfe_pkg::t_in_word   i_in_word   = '0;
    logic                  pop         = 1'b0;
    logic                  o_cfg_ready;
    logic                  full;
    logic                  empty;
    ubxfe_pkg::t_out_word  o_out_word;

    ubx_frame_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // frame predictor state
    logic [7:0]  ck_a      = '0;
    logic [7:0]  ck_b      = '0;
    logic [15:0] due_count = '0;
    logic        framing   = 1'b0;
    logic [15:0] limit_reg = ubxfe_pkg::LIMIT_RESET;

    ubxfe_pkg::t_out_word bytes_due [$];
    int        errors     = 0;
    int        cycles     = 0;
    int        burst_left = 0;
    int        words_sent = 0;

    function automatic void put_byte(logic [7:0] b, logic fend, logic rej);
        bytes_due.push_back({b, 1'b0, fend, rej});
    endfunction

    function automatic void fold(logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endfunction

    function automatic void payload_byte(logic [7:0] b);
        put_byte(b, 1'b0, 1'b0);
        fold(b);
        due_count = due_count - 16'd1;
        if (due_count == 16'd0) begin
            put_byte(ck_a, 1'b0, 1'b0);
            put_byte(ck_b, 1'b1, 1'b0);
            framing = 1'b0;
        end
    endfunction

    function automatic void encode_word(ubxfe_pkg::t_in_word w);
        int                    n0;
        ubxfe_pkg::t_out_word  tail;
        n0 = bytes_due.size();
        if (w.cmd == ubxfe_pkg::CMD_START) begin
            framing   = 1'b0;
            due_count = '0;
            ck_a      = '0;
            ck_b      = '0;
            if (w.payload_length > limit_reg) begin
                put_byte(8'h00, 1'b0, 1'b1);
            end else begin
                put_byte(ubxfe_pkg::SYNC_FIRST, 1'b0, 1'b0);
                put_byte(ubxfe_pkg::SYNC_SECOND, 1'b0, 1'b0);
                put_byte(w.msg_class, 1'b0, 1'b0);
                put_byte(w.msg_id, 1'b0, 1'b0);
                put_byte(w.payload_length[7:0], 1'b0, 1'b0);
                put_byte(w.payload_length[15:8], 1'b0, 1'b0);
                fold(w.msg_class);
                fold(w.msg_id);
                fold(w.payload_length[7:0]);
                fold(w.payload_length[15:8]);
                if (w.payload_length == 16'd0) begin
                    put_byte(ck_a, 1'b0, 1'b0);
                    put_byte(ck_b, 1'b1, 1'b0);
                end else begin
                    framing   = 1'b1;
                    due_count = w.payload_length;
                    payload_byte(w.data);
                end
            end
        end else if (framing && due_count != 16'd0) begin
            payload_byte(w.data);
        end else begin
            framing = 1'b0;
        end
        if (bytes_due.size() > n0) begin
            tail = bytes_due.pop_back();
            tail.run_last = 1'b1;
            bytes_due.push_back(tail);
        end
    endfunction

    function automatic ubxfe_pkg::t_in_word random_data_word();
        ubxfe_pkg::t_in_word w;
        w.cmd            = ubxfe_pkg::CMD_DATA;
        w.msg_class      = 8'($urandom);
        w.msg_id         = 8'($urandom);
        w.payload_length = 16'($urandom);
        w.data           = 8'($urandom);
        return w;
    endfunction

    task automatic send_item(input ubxfe_pkg::t_in_word w, input t_row_kind kind);
        int n0;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        push      <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (full);
        burst_left--;
        n0 = bytes_due.size();
        encode_word(w);
        if (kind != ROW_CHECK) begin
            while (bytes_due.size() > n0) void'(bytes_due.pop_back());
            if (kind == ROW_REJECT) bytes_due.push_back(REJECT_WORD);
        end
    endtask

    task automatic set_limit(input logic [15:0] v);
        push <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    task automatic random_frame();
        ubxfe_pkg::t_in_word w;
        int       len;
        int       extra;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 10 && limit_reg != 16'hFFFF)
            len = $urandom_range(int'(limit_reg) + 1, 65535);
        else if (roll < 20)
            len = int'(limit_reg);
        else if (roll < 30)
            len = $urandom_range(0, int'(limit_reg));
        else
            len = $urandom_range(0, (limit_reg < 16'd8) ? int'(limit_reg) : 8);
        w.cmd            = ubxfe_pkg::CMD_START;
        w.msg_class      = 8'($urandom);
        w.msg_id         = 8'($urandom);
        w.payload_length = 16'(len);
        w.data           = 8'($urandom);
        send_item(w, ROW_CHECK);
        words_sent++;
        if (len != 0 && len <= int'(limit_reg)) begin
            extra = len - 1;
            // cut long frames short; a later start abandons them
            if (extra > 24)
                extra = $urandom_range(0, 24);
            else if (extra > 0 && $urandom_range(0, 9) == 0)
                extra = $urandom_range(0, extra - 1);
            repeat (extra) begin
                send_item(random_data_word(), ROW_CHECK);
                words_sent++;
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            send_item(random_data_word(), ROW_CHECK);
            words_sent++;
        end
    endtask

    // receiver: pop with stall bursts, density redrawn from stall_pcts whenever mode_cycles wraps
    int        stall_left   = 0;
    int        stall_pct    = 0;
    int        mode_cycles  = 0;
    int        stall_pcts [4] = '{0, 15, 50, 85};
    ubxfe_pkg::t_out_word want;

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, got %h", $time, o_out_word);
            end else begin
                want = bytes_due.pop_front();
                if (o_out_word.out_byte !== want.out_byte
                        || o_out_word.run_last !== want.run_last
                        || o_out_word.frame_end !== want.frame_end
                        || o_out_word.rejected !== want.rejected) begin
                    errors++;
                    $display("%0t: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             $time, want.out_byte, want.run_last, want.frame_end,
                             want.rejected, o_out_word.out_byte, o_out_word.run_last,
                             o_out_word.frame_end, o_out_word.rejected);
                end
            end
        end
        mode_cycles++;
        if (mode_cycles == 64) begin
            mode_cycles = 0;
            stall_pct   = stall_pcts[$urandom_range(0, 3)];
        end
        if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 7);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] v;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(PLAN); i++) begin
            if (PLAN[i].kind == ROW_LIMIT)
                set_limit(PLAN[i].w.payload_length);
            else
                send_item(PLAN[i].w, PLAN[i].kind);
        end

        for (int p = 0; p < 6; p++) begin
            unique case (p)
                0: v = 16'd3;
                1: v = 16'($urandom_range(1, 65534));
                2: v = 16'hFFFF;
                3: v = 16'd0;
                4: v = 16'($urandom_range(8, 40));
                default: v = ubxfe_pkg::LIMIT_RESET;
            endcase
            set_limit(v);
            while (words_sent < (p + 1) * PHASE_WORDS) random_frame();
        end

        push <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

[ubx_frame_encoder.f]
hdl/ubxfe_pkg.sv
hdl/ubxfe_front.sv
hdl/ubxfe_cmd_fifo.sv
hdl/ubxfe_back.sv
hdl/ubx_frame_encoder.sv
bench/tb.sv
